[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion on the block clock and reset.
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CLK_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

[hw/rtl/kcet_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key change event tracker package
// Shared constants, event type and sequencer state codes.
// ----------------------------------------------------------------------------
package kcet_pkg;

  localparam int NAV_KEYS      = 16;
  localparam int ROUTING_SLOTS = 6;
  localparam int SLOT_W        = $clog2(ROUTING_SLOTS);
  localparam int ROUTE_W       = 8;
  localparam int CNT_W         = 8;
  localparam int KEY_IDX_W     = 7;
  localparam int DEF_MAX_CELLS = 128;

  localparam logic [CNT_W-1:0] CELL_COUNT_RST = 8'd44;

  localparam logic GRP_NAV   = 1'b0;
  localparam logic GRP_ROUTE = 1'b1;

  typedef struct packed {
    logic                 group;
    logic [KEY_IDX_W-1:0] index;
    logic                 pressed;
  } evt_t;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_NAV_REL = 6'b000010,
    ST_RT_REL  = 6'b000100,
    ST_NAV_PRS = 6'b001000,
    ST_RT_PRS  = 6'b010000,
    ST_FLUSH   = 6'b100000
  } state_e;

endpackage

[hw/rtl/key_change_event_tracker_unit.sv]
`timescale 1ns / 1ps
// A report is scanned as navigation releases, routing releases over the usable cells, navigation
// presses, routing presses, then the flush; usable is cell_count capped at MAX_CELLS.
// A new report is taken only in idle, after the flush; one key compared per cycle by the shared step,
// unless an event waits for the output stage. An event waits in pend_q for the next event of its
// report, or the report's end, and for a free output register, then moves to out_q and is offered.
// Reset clears both held key sets and sets cell_count to 44.
// ----------------------------------------------------------------------------
// Key change event tracker
// Compares each key report with the held key sets and streams press and
// release events, navigation and routing, in the defined order.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_change_event_tracker_unit
  import kcet_pkg::*;
#(
  parameter int MAX_CELLS = DEF_MAX_CELLS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CNT_W-1:0]  cfg_data_i,  // cell_count
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [63:0]       s_tdata_i,   // [15:0] navigation_bits, then routing_0..routing_5
  input  logic              s_tuser_i,   // [0] forget_previous
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [7:0]        m_tdata_o,   // [6:0] key_index, [7] pressed
  output logic              m_tuser_o,   // [0] key_group
  output logic              m_tlast_o    // last_event
);

  localparam int IW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0]       cell_count_q;
  logic [NAV_KEYS-1:0]    nav_held_q, nav_held_d;
  logic [MAX_CELLS-1:0]   rt_held_q, rt_held_d;
  logic [NAV_KEYS-1:0]    now_nav_q;
  logic [ROUTE_W-1:0]     slot_q [ROUTING_SLOTS];
  logic [ROUTING_SLOTS-1:0] slot_v_q, slot_v_d;

  logic [CNT_W-1:0]       usable;
  logic                   alive;
  logic [ROUTE_W-1:0]     num;
  logic [ROUTE_W-1:0]     slot_sel, slot_key;
  logic [IW-1:0]          rd_idx;
  logic                   rt_bit, match, cond, done;
  logic [3:0]             nav_idx;
  logic                   evt_valid, evt_ready, flush, flush_ready;
  evt_t                   evt;
  logic                   accept;

  assign usable = (cell_count_q > CNT_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : cell_count_q;
  assign accept = s_tvalid_i && s_tready_o;
  assign s_tready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // slot validity: list ends at the first zero, numbers above usable are skipped
  always_comb begin
    alive = 1'b1;
    for (int i = 0; i < ROUTING_SLOTS; i++) begin
      num = s_tdata_i[NAV_KEYS + ROUTE_W*i +: ROUTE_W];
      if (num == '0) begin
        alive = 1'b0;
      end
      slot_v_d[i] = alive && (num <= usable);
    end
  end

  // shared compare step: one held bit against one current bit per cycle, unless an event waits for output
  assign nav_idx  = cnt_q[3:0];
  assign slot_sel = slot_q[cnt_q[SLOT_W-1:0]];
  assign slot_key = slot_sel - ROUTE_W'(1);
  assign rd_idx   = (state_q == ST_RT_PRS) ? slot_key[IW-1:0] : cnt_q[IW-1:0];
  assign rt_bit   = rt_held_q[rd_idx];

  always_comb begin
    match = 1'b0;
    for (int i = 0; i < ROUTING_SLOTS; i++) begin
      match = match || (slot_v_q[i] && (slot_q[i] == (cnt_q + CNT_W'(1))));
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    nav_held_d = nav_held_q;
    rt_held_d  = rt_held_q;
    cond      = 1'b0;
    done      = 1'b0;
    flush     = 1'b0;
    evt.group   = GRP_NAV;
    evt.index   = cnt_q[KEY_IDX_W-1:0];
    evt.pressed = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_NAV_REL;
          cnt_d   = '0;
          if (s_tuser_i) begin
            nav_held_d = '0;
            rt_held_d  = '0;
          end
        end
      end
      ST_NAV_REL: begin
        cond = nav_held_q[nav_idx] && !now_nav_q[nav_idx];
        done = (cnt_q == CNT_W'(NAV_KEYS - 1));
        if (!cond || evt_ready) begin
          state_d = done ? ST_RT_REL : ST_NAV_REL;
          cnt_d   = done ? '0 : cnt_q + CNT_W'(1);
        end
      end
      ST_RT_REL: begin
        evt.group = GRP_ROUTE;
        cond = (cnt_q < usable) && rt_bit && !match;
        done = ({1'b0, cnt_q} + (CNT_W+1)'(1)) >= {1'b0, usable};
        if (!cond || evt_ready) begin
          state_d = done ? ST_NAV_PRS : ST_RT_REL;
          cnt_d   = done ? CNT_W'(NAV_KEYS - 1) : cnt_q + CNT_W'(1);
        end
      end
      ST_NAV_PRS: begin
        evt.pressed = 1'b1;
        cond = !nav_held_q[nav_idx] && now_nav_q[nav_idx];
        done = (cnt_q == '0);
        if (!cond || evt_ready) begin
          state_d = done ? ST_RT_PRS : ST_NAV_PRS;
          cnt_d   = done ? CNT_W'(ROUTING_SLOTS - 1) : cnt_q - CNT_W'(1);
        end
      end
      ST_RT_PRS: begin
        evt.group   = GRP_ROUTE;
        evt.pressed = 1'b1;
        evt.index   = slot_key[KEY_IDX_W-1:0];
        // held set is still the old one here, so duplicates both press
        cond = slot_v_q[cnt_q[SLOT_W-1:0]] && !rt_bit;
        done = (cnt_q == '0);
        if (!cond || evt_ready) begin
          state_d = done ? ST_FLUSH : ST_RT_PRS;
          cnt_d   = done ? '0 : cnt_q - CNT_W'(1);
        end
      end
      ST_FLUSH: begin
        flush = 1'b1;
        if (flush_ready) begin
          state_d    = ST_IDLE;
          nav_held_d = now_nav_q;
          rt_held_d  = '0;
          for (int i = 0; i < ROUTING_SLOTS; i++) begin
            if (slot_v_q[i]) begin
              rt_held_d[IW'(slot_q[i] - ROUTE_W'(1))] = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign evt_valid = cond;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      cell_count_q <= CELL_COUNT_RST;
      nav_held_q   <= '0;
      rt_held_q    <= '0;
      slot_v_q     <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      nav_held_q <= nav_held_d;
      rt_held_q  <= rt_held_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cell_count_q <= cfg_data_i;
      end
      if (accept) begin
        slot_v_q <= slot_v_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_nav_q <= s_tdata_i[NAV_KEYS-1:0];
      for (int i = 0; i < ROUTING_SLOTS; i++) begin
        slot_q[i] <= s_tdata_i[NAV_KEYS + ROUTE_W*i +: ROUTE_W];
      end
    end
  end

  kcet_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .evt_valid_i   (evt_valid),
    .evt_i         (evt),
    .evt_ready_o   (evt_ready),
    .flush_i       (flush),
    .flush_ready_o (flush_ready),
    .m_tvalid_o    (m_tvalid_o),
    .m_tready_i    (m_tready_i),
    .m_tdata_o     (m_tdata_o),
    .m_tuser_o     (m_tuser_o),
    .m_tlast_o     (m_tlast_o)
  );

  `ASSERT_DEF(a_accept_starts_scan, accept |=> (state_q == ST_NAV_REL), "scan not started")
  `ASSERT_DEF(a_slot_cnt_range, state_q == ST_RT_PRS |-> cnt_q < CNT_W'(ROUTING_SLOTS), "slot range")
  `ASSERT_DEF(a_rel_cnt_range, (state_q == ST_RT_REL && cond) |-> cnt_q < usable, "release range")

endmodule

[hw/rtl/kcet_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event output stage
// Holds one event back until the next one (or the end of the report) is
// known, so the last event of a report can carry tlast.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kcet_out_stage
  import kcet_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       evt_valid_i,
  input  evt_t       evt_i,
  output logic       evt_ready_o,
  input  logic       flush_i,
  output logic       flush_ready_o,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,  // [6:0] key_index, [7] pressed
  output logic       m_tuser_o,  // [0] key_group
  output logic       m_tlast_o   // last_event
);

  logic pend_v_q, pend_v_d;
  evt_t pend_q;
  logic out_v_q, out_v_d;
  evt_t out_q;
  logic out_last_q;
  logic out_free, move;

  assign out_free      = !out_v_q || m_tready_i;
  assign evt_ready_o   = !pend_v_q || out_free;
  assign flush_ready_o = !pend_v_q || out_free;
  // held event leaves once its successor, or the end of the report, is known and the output is free
  assign move          = pend_v_q && out_free && (evt_valid_i || flush_i);

  always_comb begin
    out_v_d = (out_v_q && !m_tready_i) || move;
    if (evt_valid_i && evt_ready_o) begin
      pend_v_d = 1'b1;
    end else if (move) begin
      pend_v_d = 1'b0;
    end else begin
      pend_v_d = pend_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_valid_i && evt_ready_o) begin
      pend_q <= evt_i;
    end
    if (move) begin
      out_q      <= pend_q;
      out_last_q <= flush_i;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = {out_q.pressed, out_q.index};
  assign m_tuser_o  = out_q.group;
  assign m_tlast_o  = out_last_q;

  `ASSERT_DEF(a_no_evt_on_flush, !(evt_valid_i && flush_i), "event offered during flush")
  `ASSERT_DEF(a_flush_marks_last, (flush_i && flush_ready_o && pend_v_q) |=> (out_v_q && out_last_q), "last event not marked")

endmodule
